FILE: rtl/assert_macros.svh
// Assertion macros for the RTL, included by page_bitmap_allocator_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/pba_pkg.sv
// Shared constants, types and controller/datapath interface structs for the page allocator.
package pba_pkg;

  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int IN_ADDR_W      = 32;
  localparam int START_W        = 24;
  localparam int STATUS_W       = 3;
  localparam int DEF_MAX_PAGES  = 4096;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int WORD_BITS      = 32;
  localparam int WB_SH          = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAGES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESERVED = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOINIT = 3'd1,
    ST_RANGE  = 3'd2,
    ST_COUNT  = 3'd3,
    ST_NORUN  = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    rd;
    logic    mark_wr;
    logic    fill_wr;
    logic    next_w;
    logic    take_hit;
    logic    done;
    status_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic    err;
    status_t err_code;
    logic    is_mark;
    logic    hit;
    logic    last_word;
    logic    fill_last;
    logic    clear_last;
  } dp_sts_t;

endpackage

FILE: rtl/page_bitmap_allocator_core.sv
// Mark requests pass the check, bitmap read and bitmap write states before their registered result strobe.
// Allocations pass the check state, then a read and an evaluate state per bitmap word
// scanned (32 pages a word), then a read and a write state per word of the found run.
// One request is in progress at a time; busy is high until its result strobe.
// After reset the bitmap is cleared one word a cycle, with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`include "assert_macros.svh"

module page_bitmap_allocator_core #(
  parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = pba_pkg::DEF_PAGE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [pba_pkg::IN_ADDR_W-1:0] in_byte_address,
  input  logic [pba_pkg::CFG_W-1:0]     in_page_count,
  output logic                          out_valid,
  output logic [pba_pkg::STATUS_W-1:0]  out_status,
  output logic [pba_pkg::START_W-1:0]   out_start_address,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]     cfg_data
);
  import pba_pkg::*;

  logic [CFG_W-1:0] pages_in_use_r;
  logic [CFG_W-1:0] reserved_low_pages_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_in_use_r       <= '0;
      reserved_low_pages_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_PAGES:    pages_in_use_r       <= cfg_data;
        CFG_IDX_RESERVED: reserved_low_pages_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pba_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_pages         (pages_in_use_r),
    .cfg_reserved      (reserved_low_pages_r),
    .in_func           (in_func),
    .in_byte_address   (in_byte_address),
    .in_page_count     (in_page_count),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_start_address (out_start_address)
  );

  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "request transfer did not raise busy")
  `ASSERT_CLK(a_result_after_work, clk, rst_n, out_valid |-> $past(busy), "result strobe without a request in progress")
  `ASSERT_CLK(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe held for two cycles")
  `ASSERT_NEVER(a_fail_addr_zero, clk, rst_n, out_valid && (out_status != ST_OK) && (out_start_address != '0), "failed request returned a nonzero address")

endmodule

FILE: rtl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pba_dp.sv
// Allocator datapath: request registers, bitmap memory, word scan and run fill logic.
module pba_dp #(
  parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = pba_pkg::DEF_PAGE_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pba_pkg::CFG_W-1:0]      cfg_pages,
  input  logic [pba_pkg::CFG_W-1:0]      cfg_reserved,
  input  logic                           in_func,
  input  logic [pba_pkg::IN_ADDR_W-1:0]  in_byte_address,
  input  logic [pba_pkg::CFG_W-1:0]      in_page_count,
  input  pba_pkg::dp_cmd_t               cmd,
  output pba_pkg::dp_sts_t               sts,
  output logic [pba_pkg::STATUS_W-1:0]   out_status,
  output logic [pba_pkg::START_W-1:0]    out_start_address
);
  import pba_pkg::*;

  localparam int CNT_W = ($clog2(MAX_PAGES + 1) > CFG_W) ? $clog2(MAX_PAGES + 1) : CFG_W;
  localparam int SH    = WB_SH;
  localparam int WB    = WORD_BITS;
  localparam int WI_W  = CNT_W - SH;
  localparam int WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PS    = $clog2(PAGE_BYTES);
  localparam int PG_W  = IN_ADDR_W - PS;
  localparam int CMP_W = (PG_W > CNT_W) ? PG_W : CNT_W;
  localparam int RUN_W = CNT_W + 1;
  localparam int SA_W  = CNT_W + PS;

  logic               func_r;
  logic [PG_W-1:0]    page_r;
  logic [CNT_W-1:0]   count_r;
  logic [WI_W-1:0]    w_r;
  logic [RUN_W-1:0]   run_r;
  logic [CNT_W-1:0]   s_r;
  logic [CNT_W-1:0]   e_r;
  status_t            out_status_r;
  logic [START_W-1:0] out_start_r;

  logic [CNT_W-1:0] pages_ext, eff, res_ext;
  logic [WI_W-1:0]  r_word, n_word, last_w, s_word, e_word, clr_last_w;
  logic [SH-1:0]    r_bit, n_bit;
  logic [WB-1:0]    rdata, blocked, fill_mask, wdata;
  logic [PG_W-1:0]  in_page;
  logic             hit;
  logic [SH-1:0]    hit_bit;
  logic [RUN_W-1:0] run_last;
  logic [CNT_W-1:0] hit_end, hit_start;
  logic [SA_W-1:0]  start_bytes;
  status_t          err_code;
  logic             err;

  // Effective page count, clamped to the capacity of the bitmap.
  assign pages_ext  = CNT_W'(cfg_pages);
  assign eff        = (pages_ext > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages_ext;
  assign res_ext    = CNT_W'(cfg_reserved);
  assign r_word     = WI_W'(res_ext >> SH);
  assign r_bit      = res_ext[SH-1:0];
  assign n_word     = WI_W'(eff >> SH);
  assign n_bit      = eff[SH-1:0];
  assign last_w     = WI_W'((eff - CNT_W'(1)) >> SH);
  assign s_word     = WI_W'(s_r >> SH);
  assign e_word     = WI_W'(e_r >> SH);
  assign clr_last_w = WI_W'(WORDS - 1);
  assign in_page    = in_byte_address[IN_ADDR_W-1:PS];

  always_comb begin
    err      = 1'b1;
    err_code = ST_OK;
    if (eff == '0) begin
      err_code = ST_NOINIT;
    end else if (!func_r) begin
      if (CMP_W'(page_r) >= CMP_W'(eff)) begin
        err_code = ST_RANGE;
      end else begin
        err = 1'b0;
      end
    end else if (count_r == '0 || count_r > eff) begin
      err_code = ST_COUNT;
    end else if (res_ext >= eff) begin
      err_code = ST_NORUN;
    end else begin
      err = 1'b0;
    end
  end

  // Pages below the reserved limit or past the page count count as used.
  always_comb begin
    for (int i = 0; i < WB; i++) begin
      blocked[i] = rdata[i]
                 | (w_r < r_word) | ((w_r == r_word) && (SH'(i) < r_bit))
                 | (w_r > n_word) | ((w_r == n_word) && (SH'(i) >= n_bit));
      fill_mask[i] = ((w_r > s_word) || ((w_r == s_word) && (SH'(i) >= s_r[SH-1:0])))
                  && ((w_r < e_word) || ((w_r == e_word) && (SH'(i) <= e_r[SH-1:0])));
    end
  end

  // Free-run length ending at each bit of the word; the lowest bit reaching
  // the requested count ends the first-fit run.
  always_comb begin
    logic             any;
    logic [SH-1:0]    lu;
    logic [RUN_W-1:0] run_i;
    hit      = 1'b0;
    hit_bit  = '0;
    run_last = '0;
    for (int i = 0; i < WB; i++) begin
      any = 1'b0;
      lu  = '0;
      for (int j = 0; j < WB; j++) begin
        if (j <= i && blocked[j]) begin
          any = 1'b1;
          lu  = SH'(j);
        end
      end
      run_i = any ? RUN_W'(SH'(i) - lu) : run_r + RUN_W'(i + 1);
      if (!hit && run_i >= RUN_W'(count_r)) begin
        hit     = 1'b1;
        hit_bit = SH'(i);
      end
      if (i == WB - 1) begin
        run_last = run_i;
      end
    end
  end

  assign hit_end     = {w_r, hit_bit};
  assign hit_start   = hit_end + CNT_W'(1) - count_r;
  assign start_bytes = SA_W'(s_r) << PS;

  always_comb begin
    wdata = '0;
    if (cmd.mark_wr) begin
      wdata = rdata | (WB'(1) << page_r[SH-1:0]);
    end else if (cmd.fill_wr) begin
      wdata = rdata | fill_mask;
    end
  end

  pba_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.mark_wr | cmd.fill_wr),
    .waddr (w_r[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (w_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else if (cmd.load) begin
      w_r <= in_func ? r_word : WI_W'(in_page >> SH);
    end else if (cmd.take_hit) begin
      w_r <= WI_W'(hit_start >> SH);
    end else if (cmd.next_w || cmd.clr_wr) begin
      w_r <= w_r + WI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      page_r  <= in_page;
      count_r <= CNT_W'(in_page_count);
      run_r   <= '0;
    end else if (cmd.next_w) begin
      run_r <= run_last;
    end
    if (cmd.take_hit) begin
      s_r <= hit_start;
      e_r <= hit_end;
    end
    if (cmd.done) begin
      out_status_r <= cmd.res;
      out_start_r  <= (cmd.res == ST_OK && func_r) ? START_W'(start_bytes) : '0;
    end
  end

  assign sts.err        = err;
  assign sts.err_code   = err_code;
  assign sts.is_mark    = !func_r;
  assign sts.hit        = hit;
  assign sts.last_word  = (w_r == last_w);
  assign sts.fill_last  = (w_r == e_word);
  assign sts.clear_last = (w_r == clr_last_w);

  assign out_status        = out_status_r;
  assign out_start_address = out_start_r;

endmodule

FILE: rtl/pba_ctrl.sv
// Allocator controller: sequences bitmap clearing, marking, scanning and run filling.
module pba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pba_pkg::dp_sts_t sts,
  output pba_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             out_valid
);
  import pba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_MARK_RD,
    S_MARK_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FILL_RD,
    S_FILL_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.res       = ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          cmd.done      = 1'b1;
          cmd.res       = sts.err_code;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.is_mark) begin
          state_nxt = S_MARK_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr   = 1'b1;
        cmd.done      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_FILL_RD;
        end else if (sts.last_word) begin
          cmd.done      = 1'b1;
          cmd.res       = ST_NORUN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.next_w = 1'b1;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_FILL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          cmd.done      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.next_w = 1'b1;
          state_nxt  = S_FILL_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
